@@ rtl/mfs_pkg.sv @@
`default_nettype none

package mfs_pkg;

    // Table geometry (row counts are powers of two)
    localparam int USER_ROWS   = 1024;
    localparam int ITEM_ROWS   = 4096;
    localparam int MAX_FACTORS = 16;

    localparam int ELEM_W = 16;
    localparam int ROW_W  = MAX_FACTORS * ELEM_W;
    localparam int UROW_W = $clog2(USER_ROWS);
    localparam int IROW_W = $clog2(ITEM_ROWS);
    localparam int FI_W   = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
    localparam int FC_W   = $clog2(MAX_FACTORS + 1);
    localparam int ACC_W  = 2 * ELEM_W + FC_W;

    // Item kinds
    localparam logic [2:0] KIND_TRAIN      = 3'd0;
    localparam logic [2:0] KIND_PREDICT    = 3'd1;
    localparam logic [2:0] KIND_WRITE_USER = 3'd2;
    localparam logic [2:0] KIND_WRITE_ITEM = 3'd3;
    localparam logic [2:0] KIND_READ_USER  = 3'd4;
    localparam logic [2:0] KIND_READ_ITEM  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_FACTORS = 2'd0;
    localparam logic [1:0] CFG_STEP    = 2'd1;
    localparam logic [1:0] CFG_REG     = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LATCH,
        S_DOT,
        S_PRED,
        S_UPA,
        S_UPB,
        S_WB,
        S_FIN
    } state_t;

    typedef struct packed {
        logic                     clip;
        logic signed [ELEM_W-1:0] value;
    } sat_t;

    // Clip a wide signed value to 16 bits and flag the clip
    function automatic sat_t sat16(input logic signed [39:0] v);
        sat_t r;
        if (v > 40'sd32767) begin
            r.clip  = 1'b1;
            r.value = 16'sh7fff;
        end else if (v < -40'sd32768) begin
            r.clip  = 1'b1;
            r.value = 16'sh8000;
        end else begin
            r.clip  = 1'b0;
            r.value = v[ELEM_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mfs_ram.sv @@
`default_nettype none

module mfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/matrix_factorization_sgd.sv @@
`default_nettype none

// Funk SVD trainer. User and item factor rows (signed Q4.12) sit in two
// row-wide synchronous RAMs; each item reads both rows in one access, works
// on them one factor per step, and writes the rows back for factor writes and
// for training with nf = min(factors_in_use, 16) above zero. A training item
// takes nf dot-product steps, a prediction step and two update steps per
// factor; a prediction takes the dot-product steps and the prediction step;
// factor reads and unused kinds only read the rows. The engine stalls its
// input until the item has finished and its result has entered the output
// register, and then takes the next transfer from idle. A finished result
// waits in the output register while the next item is already taken.
// Table contents are undefined until written; there is no clearing pass.
module matrix_factorization_sgd (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [9:0]  user,
    input  wire logic [11:0] item,
    input  wire logic signed [15:0] rating,
    input  wire logic [3:0]  factor_index,
    input  wire logic signed [15:0] factor_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [15:0] prediction,
    output logic signed [15:0] error,
    output logic signed [15:0] factor_value,
    output logic             saturated,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    mfs_pkg::state_t state_reg, state_next;

    logic [4:0]  factors_reg;
    logic [15:0] step_reg;
    logic [15:0] lambda_reg;

    logic [2:0]                       kind_reg;
    logic [mfs_pkg::UROW_W-1:0]       urow_reg;
    logic [mfs_pkg::IROW_W-1:0]       irow_reg;
    logic signed [15:0]               rating_reg;
    logic [3:0]                       fidx_reg;
    logic signed [15:0]               fdata_reg;
    logic [mfs_pkg::FC_W-1:0]         k_reg;
    logic signed [mfs_pkg::ACC_W-1:0] acc_reg;
    logic signed [15:0]               pred_reg;
    logic signed [15:0]               err_reg;
    logic signed [15:0]               fval_reg;
    logic                             sat_reg;
    logic signed [36:0]               gp_reg;
    logic signed [36:0]               gq_reg;
    logic signed [15:0]               p_row_reg [mfs_pkg::MAX_FACTORS];
    logic signed [15:0]               q_row_reg [mfs_pkg::MAX_FACTORS];

    logic                             out_valid_reg;
    logic signed [15:0]               out_pred_reg;
    logic signed [15:0]               out_err_reg;
    logic signed [15:0]               out_fval_reg;
    logic                             out_sat_reg;

    logic [mfs_pkg::ROW_W-1:0] u_rdata, i_rdata, u_wdata, i_wdata;
    logic                      u_we, i_we;

    logic                      in_xfer;
    logic                      out_free;
    logic [mfs_pkg::FC_W-1:0]  nf;
    logic [mfs_pkg::FI_W-1:0]  k_idx;
    logic                      fidx_ok;
    logic                      is_train, is_pred;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != mfs_pkg::S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign k_idx    = k_reg[mfs_pkg::FI_W-1:0];
    assign fidx_ok  = (int'(fidx_reg) < mfs_pkg::MAX_FACTORS);
    assign is_train = (kind_reg == mfs_pkg::KIND_TRAIN);
    assign is_pred  = (kind_reg == mfs_pkg::KIND_PREDICT);

    // Clamp the factor count to the row size
    always_comb
    begin
        if (int'(factors_reg) > mfs_pkg::MAX_FACTORS)
        begin
            nf = mfs_pkg::FC_W'(mfs_pkg::MAX_FACTORS);
        end
        else
        begin
            nf = mfs_pkg::FC_W'(factors_reg);
        end
    end

    // Factor tables, one row per entry
    mfs_ram #(
        .WIDTH (mfs_pkg::ROW_W),
        .DEPTH (mfs_pkg::USER_ROWS)
    ) u_user_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (urow_reg),
        .wdata (u_wdata),
        .raddr (urow_reg),
        .rdata (u_rdata)
    );

    mfs_ram #(
        .WIDTH (mfs_pkg::ROW_W),
        .DEPTH (mfs_pkg::ITEM_ROWS)
    ) u_item_ram (
        .clk   (clk),
        .we    (i_we),
        .waddr (irow_reg),
        .wdata (i_wdata),
        .raddr (irow_reg),
        .rdata (i_rdata)
    );

    // Pack working rows for write-back
    always_comb
    begin
        for (int i = 0; i < mfs_pkg::MAX_FACTORS; i++)
        begin
            u_wdata[i*mfs_pkg::ELEM_W +: mfs_pkg::ELEM_W] = p_row_reg[i];
            i_wdata[i*mfs_pkg::ELEM_W +: mfs_pkg::ELEM_W] = q_row_reg[i];
        end
    end

    assign u_we = (state_reg == mfs_pkg::S_WB)
                  && (is_train || kind_reg == mfs_pkg::KIND_WRITE_USER);
    assign i_we = (state_reg == mfs_pkg::S_WB)
                  && (is_train || kind_reg == mfs_pkg::KIND_WRITE_ITEM);

    // Datapath for the current step
    logic signed [31:0]  dot_prod;
    logic signed [39:0]  pred_round;
    mfs_pkg::sat_t       pred_sat, err_sat, np_sat, nq_sat;
    logic signed [31:0]  eq_prod, ep_prod;
    logic signed [32:0]  lp_prod, lq_prod;
    logic signed [53:0]  dp_prod, dq_prod;
    logic signed [21:0]  dp, dq;

    always_comb
    begin
        dot_prod   = p_row_reg[k_idx] * q_row_reg[k_idx];
        pred_round = (40'(acc_reg) + 40'sd2048) >>> 12;
        pred_sat   = mfs_pkg::sat16(pred_round);
        err_sat    = mfs_pkg::sat16(40'(rating_reg) - 40'(pred_sat.value));
        eq_prod    = err_reg * q_row_reg[k_idx];
        ep_prod    = err_reg * p_row_reg[k_idx];
        lp_prod    = $signed({1'b0, lambda_reg}) * p_row_reg[k_idx];
        lq_prod    = $signed({1'b0, lambda_reg}) * q_row_reg[k_idx];
        dp_prod    = $signed({1'b0, step_reg}) * gp_reg;
        dq_prod    = $signed({1'b0, step_reg}) * gq_reg;
        dp         = 22'((dp_prod + 54'sd2147483648) >>> 32);
        dq         = 22'((dq_prod + 54'sd2147483648) >>> 32);
        np_sat     = mfs_pkg::sat16(40'(p_row_reg[k_idx]) + 40'(dp));
        nq_sat     = mfs_pkg::sat16(40'(q_row_reg[k_idx]) + 40'(dq));
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfs_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = mfs_pkg::S_READ;
                end
            end
            mfs_pkg::S_READ:
            begin
                state_next = mfs_pkg::S_LATCH;
            end
            mfs_pkg::S_LATCH:
            begin
                priority if (is_train || is_pred)
                begin
                    state_next = (nf == '0) ? mfs_pkg::S_PRED : mfs_pkg::S_DOT;
                end
                else if (kind_reg == mfs_pkg::KIND_WRITE_USER
                         || kind_reg == mfs_pkg::KIND_WRITE_ITEM)
                begin
                    state_next = mfs_pkg::S_WB;
                end
                else
                begin
                    state_next = mfs_pkg::S_FIN;
                end
            end
            mfs_pkg::S_DOT:
            begin
                if (k_reg + 1'b1 == nf)
                begin
                    state_next = mfs_pkg::S_PRED;
                end
            end
            mfs_pkg::S_PRED:
            begin
                if (is_train && nf != '0)
                begin
                    state_next = mfs_pkg::S_UPA;
                end
                else
                begin
                    state_next = mfs_pkg::S_FIN;
                end
            end
            mfs_pkg::S_UPA:
            begin
                state_next = mfs_pkg::S_UPB;
            end
            mfs_pkg::S_UPB:
            begin
                state_next = (k_reg + 1'b1 == nf) ? mfs_pkg::S_WB : mfs_pkg::S_UPA;
            end
            mfs_pkg::S_WB:
            begin
                state_next = mfs_pkg::S_FIN;
            end
            mfs_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = mfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mfs_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            factors_reg   <= 5'd16;
            step_reg      <= 16'd655;
            lambda_reg    <= 16'd655;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mfs_pkg::S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mfs_pkg::CFG_FACTORS: factors_reg <= cfg_data[4:0];
                    mfs_pkg::CFG_STEP:    step_reg    <= cfg_data;
                    mfs_pkg::CFG_REG:     lambda_reg  <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mfs_pkg::S_IDLE:
            begin
                kind_reg   <= kind;
                urow_reg   <= user[mfs_pkg::UROW_W-1:0];
                irow_reg   <= item[mfs_pkg::IROW_W-1:0];
                rating_reg <= rating;
                fidx_reg   <= factor_index;
                fdata_reg  <= factor_data;
                k_reg      <= '0;
                acc_reg    <= '0;
                pred_reg   <= '0;
                err_reg    <= '0;
                fval_reg   <= '0;
                sat_reg    <= 1'b0;
            end
            mfs_pkg::S_READ:
            begin
            end
            mfs_pkg::S_LATCH:
            begin
                // Take both rows; fold in a single-element write or pick a read
                for (int i = 0; i < mfs_pkg::MAX_FACTORS; i++)
                begin
                    p_row_reg[i] <= (kind_reg == mfs_pkg::KIND_WRITE_USER && fidx_ok
                                     && i == int'(fidx_reg))
                                    ? fdata_reg
                                    : u_rdata[i*mfs_pkg::ELEM_W +: mfs_pkg::ELEM_W];
                    q_row_reg[i] <= (kind_reg == mfs_pkg::KIND_WRITE_ITEM && fidx_ok
                                     && i == int'(fidx_reg))
                                    ? fdata_reg
                                    : i_rdata[i*mfs_pkg::ELEM_W +: mfs_pkg::ELEM_W];
                end
                if (fidx_ok)
                begin
                    if (kind_reg == mfs_pkg::KIND_READ_USER)
                    begin
                        fval_reg <= u_rdata[int'(fidx_reg)*mfs_pkg::ELEM_W +: mfs_pkg::ELEM_W];
                    end
                    if (kind_reg == mfs_pkg::KIND_READ_ITEM)
                    begin
                        fval_reg <= i_rdata[int'(fidx_reg)*mfs_pkg::ELEM_W +: mfs_pkg::ELEM_W];
                    end
                end
            end
            mfs_pkg::S_DOT:
            begin
                acc_reg <= acc_reg + mfs_pkg::ACC_W'(dot_prod);
                k_reg   <= k_reg + 1'b1;
            end
            mfs_pkg::S_PRED:
            begin
                pred_reg <= pred_sat.value;
                k_reg    <= '0;
                if (is_train)
                begin
                    err_reg <= err_sat.value;
                    sat_reg <= sat_reg | pred_sat.clip | err_sat.clip;
                end
                else
                begin
                    sat_reg <= sat_reg | pred_sat.clip;
                end
            end
            mfs_pkg::S_UPA:
            begin
                // Gradients from the old p and q
                gp_reg <= (37'(eq_prod) <<< 4) - 37'(lp_prod);
                gq_reg <= (37'(ep_prod) <<< 4) - 37'(lq_prod);
            end
            mfs_pkg::S_UPB:
            begin
                p_row_reg[k_idx] <= np_sat.value;
                q_row_reg[k_idx] <= nq_sat.value;
                sat_reg          <= sat_reg | np_sat.clip | nq_sat.clip;
                k_reg            <= k_reg + 1'b1;
            end
            mfs_pkg::S_WB:
            begin
            end
            mfs_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    out_pred_reg <= pred_reg;
                    out_err_reg  <= err_reg;
                    out_fval_reg <= fval_reg;
                    out_sat_reg  <= sat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign prediction   = out_pred_reg;
    assign error        = out_err_reg;
    assign factor_value = out_fval_reg;
    assign saturated    = out_sat_reg;

    // Checks
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == mfs_pkg::S_READ)
        else $error("accepted item did not start a row read");

    a_dot_kind: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mfs_pkg::S_DOT |-> (is_train || is_pred))
        else $error("dot product on a non-compute kind");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mfs_pkg::S_DOT || state_reg == mfs_pkg::S_UPB) |-> k_reg < nf)
        else $error("factor step past factor count");

    a_wb_only: assert property (@(posedge clk) disable iff (!rst_n)
        (u_we || i_we) |-> $past(state_reg) == mfs_pkg::S_LATCH
                           || $past(state_reg) == mfs_pkg::S_UPB)
        else $error("table write outside write-back");

endmodule

`default_nettype wire
